>>> rtl/mme_pkg.sv
// Shared types, constants and helper functions for the matrix multiply engine.
package mme_pkg;

  localparam int MAX_DIM   = 16;
  localparam int ELEM_W    = 16;
  localparam int RES_W     = 36;
  localparam int ROW_W     = 4;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IDX_W  = (DIM_W > ROW_W) ? DIM_W : ROW_W;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DCNT_W = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int GROW_W = PROD_W + DIM_W + 1;
  localparam int SUM_W  = (GROW_W > RES_W + 1) ? GROW_W : RES_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COLS  = CFG_IDX_W'(2);
  localparam logic [CFG_W-1:0]     CFG_RESET        = CFG_W'(16);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(RES_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic load;
    logic status;
  } resp_t;

  typedef struct packed {
    logic [DCNT_W-1:0] rows;
    logic [DCNT_W-1:0] inner;
    logic [DCNT_W-1:0] cols;
  } dims_t;

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    logic [ADDR_W+IDX_W-1:0] full;
    full = (ADDR_W + IDX_W)'(r) * (ADDR_W + IDX_W)'(MAX_DIM) + (ADDR_W + IDX_W)'(c);
    return full[ADDR_W-1:0];
  endfunction

  function automatic logic [DCNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DCNT_W-1:0] ext;
    ext = DCNT_W'(v);
    return (ext > DCNT_W'(MAX_DIM)) ? DCNT_W'(MAX_DIM) : ext;
  endfunction

  function automatic logic signed [RES_W-1:0] saturate(input logic signed [SUM_W-1:0] s);
    logic signed [RES_W-1:0] r;
    if (s > SAT_HI) begin
      r = SAT_HI[RES_W-1:0];
    end else if (s < SAT_LO) begin
      r = SAT_LO[RES_W-1:0];
    end else begin
      r = s[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/mme_in_if.sv
// Input channel: op, row, col and element value with valid/ready.
interface mme_in_if;
  logic                               valid;
  logic                               ready;
  logic [mme_pkg::OP_W-1:0]           op;
  logic [mme_pkg::ROW_W-1:0]          row;
  logic [mme_pkg::ROW_W-1:0]          col;
  logic signed [mme_pkg::ELEM_W-1:0]  value;

  modport source (output valid, output op, output row, output col, output value, input ready);
  modport sink   (input valid, input op, input row, input col, input value, output ready);
endinterface

>>> rtl/mme_out_if.sv
// Result channel: dot product and status with valid/ready.
interface mme_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mme_pkg::RES_W-1:0]  result;
  logic                              status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

>>> rtl/mme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mme_ctrl.sv
// Sequencer: decodes transactions, writes the matrix RAMs and walks the inner index.
module mme_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  mme_in_if.sink                        in_ch,
  input  mme_pkg::dims_t                dims,
  input  logic                          out_free,
  input  logic                          mac_done,
  output logic                          a_we,
  output logic                          b_we,
  output logic [mme_pkg::ADDR_W-1:0]    wr_addr,
  output logic [mme_pkg::ELEM_W-1:0]    wr_data,
  output logic [mme_pkg::ADDR_W-1:0]    rd_a_addr,
  output logic [mme_pkg::ADDR_W-1:0]    rd_b_addr,
  output mme_pkg::mac_ctl_t             mac_ctl,
  output mme_pkg::resp_t                resp
);

  mme_pkg::state_t                 state_r, state_nxt;
  logic [mme_pkg::IDX_W-1:0]       row_r, row_nxt;
  logic [mme_pkg::IDX_W-1:0]       col_r, col_nxt;
  logic [mme_pkg::DCNT_W-1:0]      len_r, len_nxt;
  logic [mme_pkg::DIM_W-1:0]       k_r, k_nxt;
  logic                            accept;
  logic                            k_last;
  logic [mme_pkg::DCNT_W-1:0]      row_d, col_d;
  logic [mme_pkg::IDX_W-1:0]       row_x, col_x, k_x;

  assign in_ch.ready = (state_r == mme_pkg::ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign row_d = mme_pkg::DCNT_W'(in_ch.row);
  assign col_d = mme_pkg::DCNT_W'(in_ch.col);
  assign row_x = mme_pkg::IDX_W'(in_ch.row);
  assign col_x = mme_pkg::IDX_W'(in_ch.col);
  assign k_x   = mme_pkg::IDX_W'(k_r);
  assign k_last = (mme_pkg::DCNT_W'(k_r) == (len_r - mme_pkg::DCNT_W'(1)));

  assign wr_addr   = mme_pkg::mat_addr(row_x, col_x);
  assign wr_data   = in_ch.value;
  assign rd_a_addr = mme_pkg::mat_addr(row_r, k_x);
  assign rd_b_addr = mme_pkg::mat_addr(k_x, col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
    len_r <= len_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    a_we      = 1'b0;
    b_we      = 1'b0;
    mac_ctl   = '0;
    resp      = '0;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        if (accept) begin
          resp.load   = 1'b1;
          resp.status = mme_pkg::STATUS_ERR;
          case (mme_pkg::op_t'(in_ch.op))
            mme_pkg::OP_WRITE_A: begin
              if (row_d < dims.rows && col_d < dims.inner) begin
                a_we        = 1'b1;
                resp.status = mme_pkg::STATUS_OK;
              end
            end
            mme_pkg::OP_WRITE_B: begin
              if (row_d < dims.inner && col_d < dims.cols) begin
                b_we        = 1'b1;
                resp.status = mme_pkg::STATUS_OK;
              end
            end
            mme_pkg::OP_READ: begin
              if (row_d < dims.rows && col_d < dims.cols) begin
                resp.status = mme_pkg::STATUS_OK;
                if (dims.inner != '0) begin
                  // result comes from the MAC unit later
                  resp.load = 1'b0;
                  row_nxt   = row_x;
                  col_nxt   = col_x;
                  len_nxt   = dims.inner;
                  k_nxt     = '0;
                  state_nxt = mme_pkg::ST_RUN;
                end
              end
            end
            default: begin
              resp.status = mme_pkg::STATUS_ERR;
            end
          endcase
        end
      end
      mme_pkg::ST_RUN: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = (k_r == '0);
        mac_ctl.last  = k_last;
        k_nxt         = k_r + mme_pkg::DIM_W'(1);
        if (k_last) begin
          state_nxt = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = mme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mme_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mme_mac.sv
// Pipelined multiply-accumulate unit with saturation to the result width.
module mme_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mme_pkg::mac_ctl_t                  ctl,
  input  logic signed [mme_pkg::ELEM_W-1:0]  a_data,
  input  logic signed [mme_pkg::ELEM_W-1:0]  b_data,
  output logic                               done,
  output logic signed [mme_pkg::RES_W-1:0]   result
);

  mme_pkg::mac_ctl_t                   s1_r, s2_r;
  logic signed [mme_pkg::PROD_W-1:0]   prod_r;
  logic signed [mme_pkg::SUM_W-1:0]    acc_r, acc_nxt;
  logic                                done_r;

  // s1 lines up with RAM read data, s2 with the registered product
  always_comb begin
    acc_nxt = acc_r;
    if (s2_r.valid) begin
      acc_nxt = (s2_r.first ? '0 : acc_r) + mme_pkg::SUM_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= ctl;
      s2_r   <= s1_r;
      done_r <= s2_r.valid && s2_r.last;
    end
    prod_r <= a_data * b_data;
    acc_r  <= acc_nxt;
  end

  assign done   = done_r;
  assign result = mme_pkg::saturate(acc_r);

endmodule

>>> rtl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: config registers, RAMs, sequencer, MAC, output.
//
// Two 16x16 matrices of signed Q8.8 elements are held in two RAMs (A and B), loaded one
// element per transaction with op 0 and op 1. Op 2 returns element (row, col) of A x B as
// a signed Q20.16 value. A write, a rejected transaction or a read with zero inner length
// answers in the cycle after it is accepted; the next can be taken in the following cycle.
// Other reads walk the inner dimension through a single MAC unit fed by the RAM read ports,
// one term per cycle, and hold off new transactions until the MAC result reaches the
// output. A result held at the output does not block acceptance once it is being taken.
// The dimension registers apply to transactions accepted after they are written.
module matrix_multiply_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  mme_in_if.sink                              in_ch,
  mme_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [mme_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [mme_pkg::CFG_W-1:0]            rows_r, inner_r, cols_r;
  mme_pkg::dims_t                       dims;
  logic                                 out_free;
  logic                                 mac_done;
  logic signed [mme_pkg::RES_W-1:0]     mac_result;
  logic                                 a_we, b_we;
  logic [mme_pkg::ADDR_W-1:0]           wr_addr, rd_a_addr, rd_b_addr;
  logic [mme_pkg::ELEM_W-1:0]           wr_data, a_rdata, b_rdata;
  mme_pkg::mac_ctl_t                    mac_ctl;
  mme_pkg::resp_t                       resp;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [mme_pkg::RES_W-1:0]     out_result_r, out_result_nxt;
  logic                                 out_status_r, out_status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mme_pkg::CFG_RESET;
      inner_r <= mme_pkg::CFG_RESET;
      cols_r  <= mme_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mme_pkg::CFG_RESULT_ROWS:  rows_r  <= cfg_wdata;
        mme_pkg::CFG_INNER_LENGTH: inner_r <= cfg_wdata;
        mme_pkg::CFG_RESULT_COLS:  cols_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign dims.rows  = mme_pkg::eff_dim(rows_r);
  assign dims.inner = mme_pkg::eff_dim(inner_r);
  assign dims.cols  = mme_pkg::eff_dim(cols_r);

  assign out_free = !out_valid_r || out_ch.ready;

  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dims      (dims),
    .out_free  (out_free),
    .mac_done  (mac_done),
    .a_we      (a_we),
    .b_we      (b_we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .mac_ctl   (mac_ctl),
    .resp      (resp)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_a_addr),
    .rdata (a_rdata)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_b_addr),
    .rdata (b_rdata)
  );

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .done   (mac_done),
    .result (mac_result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    if (resp.load) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = '0;
      out_status_nxt = resp.status;
    end else if (mac_done) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = mac_result;
      out_status_nxt = mme_pkg::STATUS_OK;
    end else if (out_ch.ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.status = out_status_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_valid_r || out_ch.ready))
    else $error("input taken while output slot is busy");

  a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(resp.load && mac_done))
    else $error("immediate response collides with MAC result");

  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op != mme_pkg::OP_READ) |=> out_valid_r)
    else $error("non-read transaction produced no response");

  a_mac_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !mac_ctl.valid)
    else $error("transaction accepted while inner loop is running");

endmodule

>>> dv/tb_matrix_multiply_engine.sv
// Self-checking testbench for the matrix multiply engine: directed and random transactions.
module tb_matrix_multiply_engine;

  localparam logic [mme_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;
  localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MAX = 16'h7FFF;
  localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MIN = 16'h8000;
  localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_NEG_ONE = 16'hFFFF;
  localparam longint SUM_HI = (64'sd1 <<< (mme_pkg::RES_W - 1)) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< (mme_pkg::RES_W - 1));
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RECV_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * (mme_pkg::MAX_DIM + 5);
  localparam int NELEM = mme_pkg::MAX_DIM * mme_pkg::MAX_DIM;

  typedef struct packed {
    logic [mme_pkg::OP_W-1:0]          op;
    logic [mme_pkg::ROW_W-1:0]         row;
    logic [mme_pkg::ROW_W-1:0]         col;
    logic signed [mme_pkg::ELEM_W-1:0] value;
  } elem_op_t;

  typedef struct packed {
    logic signed [mme_pkg::RES_W-1:0] result;
    logic                             status;
  } elem_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [mme_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [mme_pkg::CFG_W-1:0] cfg_wdata;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // engine state as seen by the predictor
  logic signed [mme_pkg::ELEM_W-1:0] a_elems [NELEM];
  logic signed [mme_pkg::ELEM_W-1:0] b_elems [NELEM];
  logic [mme_pkg::CFG_W-1:0] dim_rows = mme_pkg::CFG_RESET;
  logic [mme_pkg::CFG_W-1:0] dim_inner = mme_pkg::CFG_RESET;
  logic [mme_pkg::CFG_W-1:0] dim_cols = mme_pkg::CFG_RESET;

  // elements already written, tracked at planning time
  bit a_seen [NELEM];
  bit b_seen [NELEM];

  elem_op_t   pending_ops[$];
  elem_resp_t expected_resps[$];
  int planned = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic recv_hold = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  function automatic int clamp_dim(input logic [mme_pkg::CFG_W-1:0] v);
    return (v > mme_pkg::MAX_DIM) ? mme_pkg::MAX_DIM : int'(v);
  endfunction

  function automatic elem_resp_t matmul_response(
      input logic [mme_pkg::OP_W-1:0] op,
      input logic [mme_pkg::ROW_W-1:0] row,
      input logic [mme_pkg::ROW_W-1:0] col,
      input logic signed [mme_pkg::ELEM_W-1:0] value);
    elem_resp_t resp;
    int nr, nk, nc, k;
    longint acc;
    nr = clamp_dim(dim_rows);
    nk = clamp_dim(dim_inner);
    nc = clamp_dim(dim_cols);
    resp.result = '0;
    resp.status = mme_pkg::STATUS_ERR;
    case (op)
      mme_pkg::OP_WRITE_A: begin
        if (row < nr && col < nk) begin
          a_elems[row*mme_pkg::MAX_DIM+col] = value;
          resp.status = mme_pkg::STATUS_OK;
        end
      end
      mme_pkg::OP_WRITE_B: begin
        if (row < nk && col < nc) begin
          b_elems[row*mme_pkg::MAX_DIM+col] = value;
          resp.status = mme_pkg::STATUS_OK;
        end
      end
      mme_pkg::OP_READ: begin
        if (row < nr && col < nc) begin
          acc = 0;
          for (k = 0; k < nk; k++) begin
            acc += longint'(a_elems[row*mme_pkg::MAX_DIM+k]) *
                   longint'(b_elems[k*mme_pkg::MAX_DIM+col]);
          end
          if (acc > SUM_HI) acc = SUM_HI;
          if (acc < SUM_LO) acc = SUM_LO;
          resp.result = mme_pkg::RES_W'(acc);
          resp.status = mme_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  function automatic logic signed [mme_pkg::ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return '0;
      3: return ELEM_NEG_ONE;
      default: return mme_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [mme_pkg::ROW_W-1:0] pick_index(input int n);
    return (n == 0) ? mme_pkg::ROW_W'($urandom_range(15))
                    : mme_pkg::ROW_W'($urandom_range(n - 1));
  endfunction

  // queue one transaction; an in-range read is preceded by writes of any missing operands
  task automatic plan_op(input logic [mme_pkg::OP_W-1:0] op,
                         input logic [mme_pkg::ROW_W-1:0] row,
                         input logic [mme_pkg::ROW_W-1:0] col,
                         input logic signed [mme_pkg::ELEM_W-1:0] value);
    int nr, nk, nc, k;
    nr = clamp_dim(dim_rows);
    nk = clamp_dim(dim_inner);
    nc = clamp_dim(dim_cols);
    if (op == mme_pkg::OP_READ && row < nr && col < nc) begin
      for (k = 0; k < nk; k++) begin
        if (!a_seen[row*mme_pkg::MAX_DIM+k]) begin
          pending_ops.push_back('{mme_pkg::OP_WRITE_A, row, mme_pkg::ROW_W'(k), rand_elem()});
          a_seen[row*mme_pkg::MAX_DIM+k] = 1'b1;
          planned++;
        end
        if (!b_seen[k*mme_pkg::MAX_DIM+col]) begin
          pending_ops.push_back('{mme_pkg::OP_WRITE_B, mme_pkg::ROW_W'(k), col, rand_elem()});
          b_seen[k*mme_pkg::MAX_DIM+col] = 1'b1;
          planned++;
        end
      end
    end
    if (op == mme_pkg::OP_WRITE_A && row < nr && col < nk) begin
      a_seen[row*mme_pkg::MAX_DIM+col] = 1'b1;
    end
    if (op == mme_pkg::OP_WRITE_B && row < nk && col < nc) begin
      b_seen[row*mme_pkg::MAX_DIM+col] = 1'b1;
    end
    pending_ops.push_back('{op, row, col, value});
    planned++;
  endtask

  task automatic plan_random(input int count);
    int goal, sel, nr, nk, nc;
    goal = planned + count;
    while (planned < goal) begin
      nr = clamp_dim(dim_rows);
      nk = clamp_dim(dim_inner);
      nc = clamp_dim(dim_cols);
      sel = $urandom_range(99);
      if (sel < 32) begin
        plan_op(mme_pkg::OP_WRITE_A, pick_index(nr), pick_index(nk), rand_elem());
      end else if (sel < 64) begin
        plan_op(mme_pkg::OP_WRITE_B, pick_index(nk), pick_index(nc), rand_elem());
      end else if (sel < 88) begin
        plan_op(mme_pkg::OP_READ, pick_index(nr), pick_index(nc),
                mme_pkg::ELEM_W'($urandom));
      end else begin
        plan_op(mme_pkg::OP_W'($urandom_range(3)), mme_pkg::ROW_W'($urandom_range(15)),
                mme_pkg::ROW_W'($urandom_range(15)), rand_elem());
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_ch.valid || expected_resps.size() != 0);
  endtask

  task automatic set_dims(input logic [mme_pkg::CFG_W-1:0] r,
                          input logic [mme_pkg::CFG_W-1:0] k,
                          input logic [mme_pkg::CFG_W-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= mme_pkg::CFG_RESULT_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr <= mme_pkg::CFG_INNER_LENGTH;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_addr <= mme_pkg::CFG_RESULT_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_rows = r;
    dim_inner = k;
    dim_cols = c;
  endtask

  // driver
  always @(posedge clk) begin
    elem_op_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_resps.push_back(matmul_response(in_ch.op, in_ch.row, in_ch.col,
                                                 in_ch.value));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= nxt.op;
          in_ch.row <= nxt.row;
          in_ch.col <= nxt.col;
          in_ch.value <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    elem_resp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_resps.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected transaction result %0d status %0b", $realtime,
                     out_ch.result, out_ch.status);
          end
          mismatches++;
        end else begin
          want = expected_resps.pop_front();
          if (out_ch.result !== want.result || out_ch.status !== want.status) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch result exp %0d got %0d, status exp %0b got %0b",
                       $realtime, want.result, out_ch.result, want.status, out_ch.status);
            end
            mismatches++;
          end
        end
      end
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall
  initial begin
    wait (hold_request);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (RECV_HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_matrix_multiply_engine failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.op = mme_pkg::OP_WRITE_A;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = mme_pkg::CFG_RESULT_ROWS;
    cfg_wdata = '0;
    for (i = 0; i < NELEM; i++) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 59;
    set_dims(5'd2, 5'd3, 5'd2);
    plan_op(mme_pkg::OP_WRITE_A, 4'd0, 4'd0, ELEM_MAX);
    plan_op(mme_pkg::OP_WRITE_A, 4'd0, 4'd1, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_A, 4'd0, 4'd2, 16'sd1);
    plan_op(mme_pkg::OP_WRITE_A, 4'd1, 4'd0, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_A, 4'd1, 4'd1, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_A, 4'd1, 4'd2, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_B, 4'd0, 4'd0, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_B, 4'd1, 4'd0, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_B, 4'd2, 4'd0, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_B, 4'd0, 4'd1, ELEM_MAX);
    plan_op(mme_pkg::OP_WRITE_B, 4'd1, 4'd1, ELEM_NEG_ONE);
    plan_op(mme_pkg::OP_WRITE_B, 4'd2, 4'd1, '0);
    plan_op(mme_pkg::OP_READ, 4'd0, 4'd0, '0);
    plan_op(mme_pkg::OP_READ, 4'd0, 4'd1, ELEM_NEG_ONE);
    plan_op(mme_pkg::OP_READ, 4'd1, 4'd0, '0);
    plan_op(mme_pkg::OP_READ, 4'd1, 4'd1, '0);
    // out-of-range indices and the unused opcode
    plan_op(mme_pkg::OP_WRITE_A, 4'd2, 4'd0, ELEM_MAX);
    plan_op(mme_pkg::OP_WRITE_A, 4'd0, 4'd3, ELEM_MAX);
    plan_op(mme_pkg::OP_WRITE_B, 4'd3, 4'd0, ELEM_MIN);
    plan_op(mme_pkg::OP_WRITE_B, 4'd0, 4'd2, ELEM_MIN);
    plan_op(mme_pkg::OP_READ, 4'd2, 4'd0, '0);
    plan_op(mme_pkg::OP_READ, 4'd0, 4'd15, '0);
    plan_op(OP_UNDEFINED, 4'd15, 4'd15, ELEM_NEG_ONE);
    plan_op(mme_pkg::OP_WRITE_A, 4'd15, 4'd15, ELEM_MAX);
    wait_quiet();

    set_dims(5'd16, 5'd16, 5'd16);
    plan_random(266);
    wait_quiet();
    set_dims(5'd31, 5'd31, 5'd31);
    plan_random(60);
    wait_quiet();

    send_idle_pct = 59;
    recv_idle_pct = 27;
    set_dims(5'd1, 5'd1, 5'd1);
    plan_random(80);
    wait_quiet();
    set_dims(5'd0, 5'd4, 5'd3);
    plan_random(50);
    wait_quiet();
    set_dims(5'd5, 5'd0, 5'd6);
    plan_random(50);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(5'd16, 5'd16, 5'd16);
    plan_random(200);
    hold_request = 1'b1;
    wait_quiet();
    repeat (4) begin
      set_dims(mme_pkg::CFG_W'($urandom_range(1, 16)), mme_pkg::CFG_W'($urandom_range(1, 16)),
               mme_pkg::CFG_W'($urandom_range(1, 16)));
      plan_random(80);
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("tb_matrix_multiply_engine passed");
    end else begin
      $display("tb_matrix_multiply_engine failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mme_pkg.sv
rtl/mme_in_if.sv
rtl/mme_out_if.sv
rtl/mme_ram.sv
rtl/mme_ctrl.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
dv/tb_matrix_multiply_engine.sv
